/* design/ttb_pkg.sv */
`default_nettype none

package ttb_pkg;

   localparam int COMP_W = 16;
   localparam int POS_W = 3 * COMP_W;
   localparam int UV_W = 2 * COMP_W;
   localparam int D_W = COMP_W + 1;
   localparam int P_W = 2 * D_W;
   localparam int R_W = P_W + 1;
   localparam int LEN_W = $clog2(R_W + 1);
   localparam int NORM_W = 31;
   localparam int SQ_W = 2 * NORM_W;
   localparam int SUM_W = 64;
   localparam int ROOT_W = 32;
   localparam int FRAC_W = COMP_W - 2;
   localparam int Q_W = COMP_W - 1;
   localparam int NUM_W = NORM_W + FRAC_W + 1;
   localparam int FRONT_STAGES = 8;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STAGES = Q_W + 1;

   typedef struct packed {
      logic                                valid;
      logic                                degen;
      logic [1:0][2:0]                     neg;
      logic [1:0][2:0][NORM_W-1:0]         comp;
      logic [1:0][SUM_W-1:0]               sum;
   } front_type;

   typedef struct packed {
      logic                                valid;
      logic                                degen;
      logic [1:0][2:0]                     neg;
      logic [1:0][2:0][NORM_W-1:0]         comp;
   } root_side_type;

   typedef struct packed {
      logic                                valid;
      logic                                degen;
      logic [1:0][2:0]                     neg;
   } div_side_type;

   typedef struct packed {
      logic [POS_W-1:0]                    tangent;
      logic [POS_W-1:0]                    binormal;
      logic                                degenerate;
   } result_type;

   function automatic logic signed [D_W-1:0] comp_diff(input logic [COMP_W-1:0] a,
                                                       input logic [COMP_W-1:0] b);
      return D_W'($signed(a)) - D_W'($signed(b));
   endfunction

   function automatic logic [LEN_W-1:0] bit_len(input logic [R_W-1:0] x);
      logic [LEN_W-1:0] n;
      n = '0;
      for (int i = 0; i < R_W; i++) begin
         if (x[i]) begin
            n = LEN_W'(i + 1);
         end
      end
      return n;
   endfunction

endpackage

`default_nettype wire

/* design/ttb_front.sv */
`default_nettype none

module ttb_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  logic [ttb_pkg::POS_W-1:0]   vertex0_position,
   input  logic [ttb_pkg::POS_W-1:0]   vertex1_position,
   input  logic [ttb_pkg::POS_W-1:0]   vertex2_position,
   input  logic [ttb_pkg::UV_W-1:0]    vertex0_uv,
   input  logic [ttb_pkg::UV_W-1:0]    vertex1_uv,
   input  logic [ttb_pkg::UV_W-1:0]    vertex2_uv,
   output ttb_pkg::front_type          front
);
   import ttb_pkg::*;

   localparam logic [LEN_W-1:0] NORM_LEN = LEN_W'(NORM_W);

   logic [FRONT_STAGES-1:0] valid_ff, valid_in;

   logic signed [D_W-1:0] e1_in [3], e2_in [3], e1_ff [3], e2_ff [3];
   logic signed [D_W-1:0] du1_in, dv1_in, du2_in, dv2_in;
   logic signed [D_W-1:0] du1_ff, dv1_ff, du2_ff, dv2_ff;

   logic signed [P_W-1:0] pdet_in [2], pdet_ff [2];
   logic signed [P_W-1:0] pa_in [2][3], pa_ff [2][3], pb_in [2][3], pb_ff [2][3];

   logic signed [R_W-1:0] det_in, det_ff;
   logic signed [R_W-1:0] raw_in [2][3], raw_ff [2][3];

   logic                  dzero_in, dzero_ff;
   logic [R_W-1:0]        magd_in [2][3], magd_ff [2][3];
   logic                  negd_in [2][3], negd_ff [2][3];
   logic [LEN_W-1:0]      len_in [2][3], len_ff [2][3];

   logic [LEN_W-1:0]      maxlen_in [2], maxlen_ff [2];
   logic [R_W-1:0]        mage_ff [2][3];
   logic                  nege_ff [2][3];
   logic                  dege_in, dege_ff;

   logic [NORM_W-1:0]     compf_in [2][3], compf_ff [2][3];
   logic                  negf_ff [2][3];
   logic                  degf_ff;

   logic [SQ_W-1:0]       sq_in [2][3], sq_ff [2][3];
   logic [NORM_W-1:0]     compg_ff [2][3];
   logic                  negg_ff [2][3];
   logic                  degg_ff;

   logic [SUM_W-1:0]      sum_in [2], sum_ff [2];
   logic [NORM_W-1:0]     comph_ff [2][3];
   logic                  negh_ff [2][3];
   logic                  degh_ff;

   assign valid_in = {valid_ff[FRONT_STAGES-2:0], in_valid};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         e1_in[k] = comp_diff(vertex1_position[(2-k)*COMP_W +: COMP_W],
                              vertex0_position[(2-k)*COMP_W +: COMP_W]);
         e2_in[k] = comp_diff(vertex2_position[(2-k)*COMP_W +: COMP_W],
                              vertex0_position[(2-k)*COMP_W +: COMP_W]);
      end
      du1_in = comp_diff(vertex1_uv[COMP_W +: COMP_W], vertex0_uv[COMP_W +: COMP_W]);
      dv1_in = comp_diff(vertex1_uv[0 +: COMP_W], vertex0_uv[0 +: COMP_W]);
      du2_in = comp_diff(vertex2_uv[COMP_W +: COMP_W], vertex0_uv[COMP_W +: COMP_W]);
      dv2_in = comp_diff(vertex2_uv[0 +: COMP_W], vertex0_uv[0 +: COMP_W]);
   end

   always_comb begin
      pdet_in[0] = P_W'(du1_ff) * P_W'(dv2_ff);
      pdet_in[1] = P_W'(du2_ff) * P_W'(dv1_ff);
      for (int k = 0; k < 3; k++) begin
         pa_in[0][k] = P_W'(dv2_ff) * P_W'(e1_ff[k]);
         pb_in[0][k] = P_W'(dv1_ff) * P_W'(e2_ff[k]);
         pa_in[1][k] = P_W'(du1_ff) * P_W'(e2_ff[k]);
         pb_in[1][k] = P_W'(du2_ff) * P_W'(e1_ff[k]);
      end
   end

   always_comb begin
      det_in = R_W'(pdet_ff[0]) - R_W'(pdet_ff[1]);
      for (int v = 0; v < 2; v++) begin
         for (int k = 0; k < 3; k++) begin
            raw_in[v][k] = R_W'(pa_ff[v][k]) - R_W'(pb_ff[v][k]);
         end
      end
   end

   always_comb begin
      dzero_in = (det_ff == '0);
      for (int v = 0; v < 2; v++) begin
         for (int k = 0; k < 3; k++) begin
            magd_in[v][k] = raw_ff[v][k][R_W-1] ? R_W'(-raw_ff[v][k]) : R_W'(raw_ff[v][k]);
            negd_in[v][k] = raw_ff[v][k][R_W-1] ^ det_ff[R_W-1];
            len_in[v][k] = bit_len(magd_in[v][k]);
         end
      end
   end

   always_comb begin
      dege_in = dzero_ff;
      for (int v = 0; v < 2; v++) begin
         maxlen_in[v] = len_ff[v][0];
         for (int k = 1; k < 3; k++) begin
            if (len_ff[v][k] > maxlen_in[v]) begin
               maxlen_in[v] = len_ff[v][k];
            end
         end
         if (maxlen_in[v] == '0) begin
            dege_in = 1'b1;
         end
      end
   end

   always_comb begin
      for (int v = 0; v < 2; v++) begin
         for (int k = 0; k < 3; k++) begin
            if (maxlen_ff[v] > NORM_LEN) begin
               compf_in[v][k] = NORM_W'(mage_ff[v][k] >> (maxlen_ff[v] - NORM_LEN));
            end else begin
               compf_in[v][k] = NORM_W'(mage_ff[v][k] << (NORM_LEN - maxlen_ff[v]));
            end
         end
      end
   end

   always_comb begin
      for (int v = 0; v < 2; v++) begin
         for (int k = 0; k < 3; k++) begin
            sq_in[v][k] = SQ_W'(compf_ff[v][k]) * SQ_W'(compf_ff[v][k]);
         end
         sum_in[v] = SUM_W'(sq_ff[v][0]) + SUM_W'(sq_ff[v][1]) + SUM_W'(sq_ff[v][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         e1_ff <= e1_in;
         e2_ff <= e2_in;
         du1_ff <= du1_in;
         dv1_ff <= dv1_in;
         du2_ff <= du2_in;
         dv2_ff <= dv2_in;
         pdet_ff <= pdet_in;
         pa_ff <= pa_in;
         pb_ff <= pb_in;
         det_ff <= det_in;
         raw_ff <= raw_in;
         dzero_ff <= dzero_in;
         magd_ff <= magd_in;
         negd_ff <= negd_in;
         len_ff <= len_in;
         maxlen_ff <= maxlen_in;
         mage_ff <= magd_ff;
         nege_ff <= negd_ff;
         dege_ff <= dege_in;
         compf_ff <= compf_in;
         negf_ff <= nege_ff;
         degf_ff <= dege_ff;
         sq_ff <= sq_in;
         compg_ff <= compf_ff;
         negg_ff <= negf_ff;
         degg_ff <= degf_ff;
         sum_ff <= sum_in;
         comph_ff <= compg_ff;
         negh_ff <= negg_ff;
         degh_ff <= degg_ff;
      end
   end

   always_comb begin
      front.valid = valid_ff[FRONT_STAGES-1];
      front.degen = degh_ff;
      for (int v = 0; v < 2; v++) begin
         front.sum[v] = sum_ff[v];
         for (int k = 0; k < 3; k++) begin
            front.neg[v][k] = negh_ff[v][k];
            front.comp[v][k] = comph_ff[v][k];
         end
      end
   end

endmodule

`default_nettype wire

/* design/ttb_isqrt.sv */
`default_nettype none

module ttb_isqrt (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [ttb_pkg::SUM_W-1:0]   radicand,
   output logic [ttb_pkg::ROOT_W-1:0]  root
);
   import ttb_pkg::*;

   logic [SQRT_STEPS-1:0][SUM_W-1:0] n_in, n_ff, r_in, r_ff;

   for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
      localparam logic [SUM_W-1:0] STEP_BIT = SUM_W'(1) << (SUM_W - 2 - 2 * g);
      logic [SUM_W-1:0] n_prev, r_prev, trial;
      if (g == 0) begin : g_first
         assign n_prev = radicand;
         assign r_prev = '0;
      end else begin : g_next
         assign n_prev = n_ff[g-1];
         assign r_prev = r_ff[g-1];
      end
      assign trial = r_prev + STEP_BIT;
      assign n_in[g] = (n_prev >= trial) ? n_prev - trial : n_prev;
      assign r_in[g] = (n_prev >= trial) ? (r_prev >> 1) + STEP_BIT : r_prev >> 1;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         n_ff <= n_in;
         r_ff <= r_in;
      end
   end

   assign root = r_ff[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

`default_nettype wire

/* design/ttb_div.sv */
`default_nettype none

module ttb_div (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [ttb_pkg::NORM_W-1:0]  comp,
   input  logic [ttb_pkg::ROOT_W-1:0]  root,
   output logic [ttb_pkg::Q_W-1:0]     quot
);
   import ttb_pkg::*;

   logic [DIV_STAGES-1:0][ROOT_W-1:0] rem_in, rem_ff, den_in, den_ff;
   logic [DIV_STAGES-1:0][Q_W-1:0]    low_in, low_ff, q_in, q_ff;
   logic [NUM_W-1:0]                  num;

   assign num = (NUM_W'(comp) << FRAC_W) + NUM_W'(root >> 1);
   assign rem_in[0] = ROOT_W'(num >> Q_W);
   assign low_in[0] = num[Q_W-1:0];
   assign den_in[0] = root;
   assign q_in[0] = '0;

   for (genvar g = 1; g < DIV_STAGES; g++) begin : g_step
      logic [ROOT_W:0] trial;
      logic            take;
      assign trial = {rem_ff[g-1], low_ff[g-1][Q_W-1]};
      assign take = (trial >= {1'b0, den_ff[g-1]});
      assign rem_in[g] = take ? ROOT_W'(trial - {1'b0, den_ff[g-1]}) : ROOT_W'(trial);
      assign low_in[g] = low_ff[g-1] << 1;
      assign q_in[g] = {q_ff[g-1][Q_W-2:0], take};
      assign den_in[g] = den_ff[g-1];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in;
         den_ff <= den_in;
         low_ff <= low_in;
         q_ff <= q_in;
      end
   end

   assign quot = q_ff[DIV_STAGES-1];

endmodule

`default_nettype wire

/* design/triangle_tangent_basis_unit.sv */
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  three positions, three texture coordinates
// rsp_      out        rsp_valid / rsp_ready  tangent, binormal, degenerate flag
//
// One triangle enters per cycle while the skid register is empty; its result passes
// through the 8 arithmetic stages, the 32-step square root and the 16-stage divider.
// Reset clears only the valid bits; there is no state carried between triangles.
// A stalled result waits in the output register and one skid register, and the
// whole pipeline holds while the skid register is full.
`default_nettype none

module triangle_tangent_basis_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ttb_pkg::POS_W-1:0]   req_vertex0_position,
   input  logic [ttb_pkg::POS_W-1:0]   req_vertex1_position,
   input  logic [ttb_pkg::POS_W-1:0]   req_vertex2_position,
   input  logic [ttb_pkg::UV_W-1:0]    req_vertex0_uv,
   input  logic [ttb_pkg::UV_W-1:0]    req_vertex1_uv,
   input  logic [ttb_pkg::UV_W-1:0]    req_vertex2_uv,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [ttb_pkg::POS_W-1:0]   rsp_tangent,
   output logic [ttb_pkg::POS_W-1:0]   rsp_binormal,
   output logic                        rsp_degenerate
);
   import ttb_pkg::*;

   logic            advance;
   front_type       front;
   root_side_type   rside_ff [SQRT_STEPS];
   div_side_type    dside_ff [DIV_STAGES];
   logic [ROOT_W-1:0] root [2];
   logic [Q_W-1:0]    quot [2][3];
   result_type      result;
   result_type      rsp_data_ff, rsp_data_in, skid_data_ff, skid_data_in;
   logic            rsp_valid_ff, rsp_valid_in, skid_valid_ff, skid_valid_in;
   logic            out_free;

   assign advance = !skid_valid_ff;
   assign req_ready = advance;

   ttb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .enable           (advance),
      .in_valid         (req_valid),
      .vertex0_position (req_vertex0_position),
      .vertex1_position (req_vertex1_position),
      .vertex2_position (req_vertex2_position),
      .vertex0_uv       (req_vertex0_uv),
      .vertex1_uv       (req_vertex1_uv),
      .vertex2_uv       (req_vertex2_uv),
      .front            (front)
   );

   for (genvar v = 0; v < 2; v++) begin : g_vec
      ttb_isqrt u_isqrt (
         .clock    (clock),
         .enable   (advance),
         .radicand (front.sum[v]),
         .root     (root[v])
      );
      for (genvar k = 0; k < 3; k++) begin : g_comp
         ttb_div u_div (
            .clock  (clock),
            .enable (advance),
            .comp   (rside_ff[SQRT_STEPS-1].comp[v][k]),
            .root   (root[v]),
            .quot   (quot[v][k])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SQRT_STEPS; i++) begin
            rside_ff[i].valid <= 1'b0;
         end
         for (int i = 0; i < DIV_STAGES; i++) begin
            dside_ff[i].valid <= 1'b0;
         end
      end else if (advance) begin
         rside_ff[0].valid <= front.valid;
         rside_ff[0].degen <= front.degen;
         rside_ff[0].neg <= front.neg;
         rside_ff[0].comp <= front.comp;
         for (int i = 1; i < SQRT_STEPS; i++) begin
            rside_ff[i] <= rside_ff[i-1];
         end
         dside_ff[0].valid <= rside_ff[SQRT_STEPS-1].valid;
         dside_ff[0].degen <= rside_ff[SQRT_STEPS-1].degen;
         dside_ff[0].neg <= rside_ff[SQRT_STEPS-1].neg;
         for (int i = 1; i < DIV_STAGES; i++) begin
            dside_ff[i] <= dside_ff[i-1];
         end
      end
   end

   always_comb begin
      logic [COMP_W-1:0] mag;
      logic [COMP_W-1:0] field;
      result.tangent = '0;
      result.binormal = '0;
      result.degenerate = dside_ff[DIV_STAGES-1].degen;
      for (int k = 0; k < 3; k++) begin
         mag = COMP_W'(quot[0][k]);
         field = dside_ff[DIV_STAGES-1].neg[0][k] ? (~mag + 1'b1) : mag;
         if (!result.degenerate) begin
            result.tangent[(2-k)*COMP_W +: COMP_W] = field;
         end
         mag = COMP_W'(quot[1][k]);
         field = dside_ff[DIV_STAGES-1].neg[1][k] ? (~mag + 1'b1) : mag;
         if (!result.degenerate) begin
            result.binormal[(2-k)*COMP_W +: COMP_W] = field;
         end
      end
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (dside_ff[DIV_STAGES-1].valid) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_data_in = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in = result;
         end
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_tangent = rsp_data_ff.tangent;
   assign rsp_binormal = rsp_data_ff.binormal;
   assign rsp_degenerate = rsp_data_ff.degenerate;

   assert property (@(posedge clock) disable iff (reset) skid_valid_ff |-> rsp_valid_ff)
      else $error("Skid register holds a transaction while the output register is empty.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_tangent == '0 && rsp_binormal == '0)
      else $error("Degenerate transaction carries nonzero vectors.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_degenerate |-> rsp_tangent != '0 && rsp_binormal != '0)
      else $error("Normalized vector came out as zero.");

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !rsp_ready |=> skid_valid_ff)
      else $error("Skid register lost a transaction while the output was stalled.");

endmodule

`default_nettype wire
